// File: rtl/core/lkc_pkg.sv
`timescale 1ns / 1ps

package lkc_pkg;

    localparam int KEY_W     = 32;
    localparam int CAP_W     = 5;
    localparam int DEPTH_DEF = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic FUNC_ACCESS = 1'b0;
    localparam logic FUNC_DUMP   = 1'b1;

    typedef enum logic
    {
        ST_IDLE,
        ST_DUMP
    } lkc_state_t;

    // Broadcast to every cell in the chain.
    typedef struct packed
    {
        logic shift_en;   // access: cells up to the shift limit take their front neighbor
        logic rotate_en;  // dump: cells take their back neighbor, tail takes the head
    } lkc_ctrl_t;

endpackage

// File: rtl/core/lkc_if.sv
`timescale 1ns / 1ps

interface lkc_in_if;
    import lkc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    func;
    logic signed [KEY_W-1:0] key;

    modport source (output valid, output func, output key, input ready);
    modport sink   (input valid, input func, input key, output ready);
endinterface

interface lkc_out_if;
    import lkc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic                    key_valid;
    logic signed [KEY_W-1:0] result_key;
    logic                    last;

    modport source (output valid, output hit, output key_valid, output result_key,
                    output last, input ready);
    modport sink   (input valid, input hit, input key_valid, input result_key,
                    input last, output ready);
endinterface

// File: rtl/core/lkc_cell.sv
`timescale 1ns / 1ps

module lkc_cell #(
    parameter int DEPTH = lkc_pkg::DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  logic                                clk,
    input  lkc_pkg::lkc_ctrl_t                  ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]          occ,
    input  logic [$clog2(DEPTH+1)-1:0]          shift_lim,
    input  logic [lkc_pkg::KEY_W-1:0]           probe_key,
    input  logic [lkc_pkg::KEY_W-1:0]           front_key,
    input  logic [lkc_pkg::KEY_W-1:0]           back_key,
    input  logic [lkc_pkg::KEY_W-1:0]           head_key,
    output logic [lkc_pkg::KEY_W-1:0]           key_out,
    output logic                                match,
    output logic [lkc_pkg::KEY_W-1:0]           tail_key
);
    import lkc_pkg::*;

    localparam int OCC_W = $clog2(DEPTH+1);
    localparam logic [OCC_W-1:0] MY_IDX = OCC_W'(IDX);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             occupied;
    logic             is_tail;

    assign occupied = MY_IDX < occ;
    assign is_tail  = occupied && (MY_IDX == occ - OCC_W'(1));
    assign match    = occupied && (key_reg == probe_key);
    assign tail_key = is_tail ? key_reg : '0;
    assign key_out  = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.shift_en && (MY_IDX <= shift_lim))
        begin
            key_next = front_key;
        end
        else if (ctrl.rotate_en)
        begin
            key_next = is_tail ? head_key : back_key;
        end
    end

    // Entries above the occupancy are never read, so the key needs no reset.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// File: rtl/core/lru_key_cache_core.sv
`timescale 1ns / 1ps
// LRU key cache: keeps up to "capacity" 32-bit keys ordered from most to least
// recently used, in a chain of compare-and-shift cells.
// Input channel in_item carries func and key. An access item (func 0) compares
// the key against every cell at once and gives one registered result in the cycle
// after it is taken: hit, or the evicted least recent key when the store was full.
// A dump item (func 1) gives one result per stored key, front first, one per
// cycle while out_item is not stalled, with last on the final one; an empty
// store gives one result with key_valid low. The chain rotates one place per
// result and is back in order after the dump. No new item is taken until the
// dump's last result is loaded. Throughput: one access per cycle when not stalled.
// The output register decouples the sides: while out_item is stalled nothing is
// lost, and a new item is taken in the cycle the waiting result leaves.
// cfg_we/cfg_wdata write the capacity (reset 16, 0 acts as 1, values above
// DEPTH act as DEPTH); write it only while the block is idle.
// Reset empties the store at once; no clearing pass is needed.
module lru_key_cache_core #(
    parameter int DEPTH = lkc_pkg::DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    lkc_in_if.sink                     in_item,
    lkc_out_if.source                  out_item,
    input  logic                       cfg_we,
    input  logic [lkc_pkg::CAP_W-1:0]  cfg_wdata
);
    import lkc_pkg::*;

    localparam int OCC_W = $clog2(DEPTH+1);
    localparam logic [7:0] DEPTH_EXT = 8'(DEPTH);

    lkc_state_t        state_reg, state_next;
    logic [CAP_W-1:0]  capacity_reg;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [OCC_W-1:0]  cnt_reg, cnt_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_hit_reg, out_hit_next;
    logic              out_kv_reg, out_kv_next;
    logic [KEY_W-1:0]  out_key_reg, out_key_next;
    logic              out_last_reg, out_last_next;
    logic              out_load;

    lkc_ctrl_t         ctrl;
    logic [KEY_W-1:0]  cell_key [DEPTH];
    logic [KEY_W-1:0]  tail_keys [DEPTH];
    logic [DEPTH-1:0]  match;
    logic              hit_any;
    logic [OCC_W-1:0]  hit_pos;
    logic [OCC_W-1:0]  shift_lim;
    logic [KEY_W-1:0]  evict_key;
    logic [7:0]        cap_eff;
    logic              room;
    logic              out_free;
    logic              in_ready;
    logic              in_accept;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [KEY_W-1:0] front_k;
            logic [KEY_W-1:0] back_k;
            if (gi == 0)
            begin : g_head
                assign front_k = in_item.key;
            end
            else
            begin : g_mid
                assign front_k = cell_key[gi-1];
            end
            if (gi == DEPTH-1)
            begin : g_end
                assign back_k = cell_key[gi];
            end
            else
            begin : g_nxt
                assign back_k = cell_key[gi+1];
            end

            lkc_cell #(
                .DEPTH (DEPTH),
                .IDX   (gi)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occ       (occ_reg),
                .shift_lim (shift_lim),
                .probe_key (in_item.key),
                .front_key (front_k),
                .back_key  (back_k),
                .head_key  (cell_key[0]),
                .key_out   (cell_key[gi]),
                .match     (match[gi]),
                .tail_key  (tail_keys[gi])
            );
        end
    endgenerate

    // Stored keys are unique, so at most one cell matches.
    always_comb
    begin
        hit_pos   = '0;
        evict_key = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (match[i])
            begin
                hit_pos = hit_pos | OCC_W'(i);
            end
            evict_key = evict_key | tail_keys[i];
        end
    end

    assign hit_any = |match;

    always_comb
    begin
        cap_eff = {3'b000, capacity_reg};
        if (cap_eff == 8'd0)
        begin
            cap_eff = 8'd1;
        end
        if (cap_eff > DEPTH_EXT)
        begin
            cap_eff = DEPTH_EXT;
        end
    end

    assign room = 8'(occ_reg) < cap_eff;

    always_comb
    begin
        if (hit_any)
        begin
            shift_lim = hit_pos;
        end
        else if (room)
        begin
            shift_lim = occ_reg;
        end
        else
        begin
            shift_lim = occ_reg - OCC_W'(1);
        end
    end

    assign out_free  = !out_valid_reg || out_item.ready;
    assign in_accept = in_item.valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        cnt_next       = cnt_reg;
        in_ready       = 1'b0;
        ctrl.shift_en  = 1'b0;
        ctrl.rotate_en = 1'b0;
        out_load       = 1'b0;
        out_hit_next   = out_hit_reg;
        out_kv_next    = out_kv_reg;
        out_key_next   = out_key_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = out_free;
                if (in_accept)
                begin
                    if (in_item.func == FUNC_DUMP)
                    begin
                        if (occ_reg == '0)
                        begin
                            out_load      = 1'b1;
                            out_hit_next  = 1'b0;
                            out_kv_next   = 1'b0;
                            out_key_next  = '0;
                            out_last_next = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_DUMP;
                            cnt_next   = '0;
                        end
                    end
                    else
                    begin
                        ctrl.shift_en = 1'b1;
                        out_load      = 1'b1;
                        out_hit_next  = hit_any;
                        out_kv_next   = !hit_any && !room;
                        out_key_next  = (!hit_any && !room) ? evict_key : '0;
                        out_last_next = 1'b1;
                        if (!hit_any && room)
                        begin
                            occ_next = occ_reg + OCC_W'(1);
                        end
                    end
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    ctrl.rotate_en = 1'b1;
                    out_load       = 1'b1;
                    out_hit_next   = 1'b0;
                    out_kv_next    = 1'b1;
                    out_key_next   = cell_key[0];
                    out_last_next  = (cnt_reg == occ_reg - OCC_W'(1));
                    cnt_next       = cnt_reg + OCC_W'(1);
                    if (cnt_reg == occ_reg - OCC_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_item.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            capacity_reg  <= CAP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_hit_reg  <= out_hit_next;
        out_kv_reg   <= out_kv_next;
        out_key_reg  <= out_key_next;
        out_last_reg <= out_last_next;
    end

    assign in_item.ready       = in_ready;
    assign out_item.valid      = out_valid_reg;
    assign out_item.hit        = out_hit_reg;
    assign out_item.key_valid  = out_kv_reg;
    assign out_item.result_key = out_key_reg;
    assign out_item.last       = out_last_reg;

endmodule
